### design/assert_macros.svh
// Assertion macros shared by the responder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### design/mrr_pkg.sv
// Package: constants, codes and types of the Modbus RTU request responder.
`default_nettype none
package mrr_pkg;
    localparam int BYTE_W      = 8;
    localparam int MAX_REGS    = 8;
    localparam int TABLE_DEPTH = 8;
    localparam int TABLE_IDX_W = $clog2(TABLE_DEPTH);
    localparam int REG_LIMIT   = (MAX_REGS < TABLE_DEPTH) ? MAX_REGS : TABLE_DEPTH;
    localparam int REG_CNT_W   = $clog2(REG_LIMIT + 1);
    localparam int CRC_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int S_TDATA_W   = 24;

    localparam logic [CRC_W-1:0]  CRC_INIT         = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY         = 16'hA001;
    localparam logic [BYTE_W-1:0] WRITE_FUNC_LIMIT = 8'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_ADDRESS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLY_FUNCTION = 1'b1;
    localparam logic [BYTE_W-1:0]    RESET_REPLY_ADDRESS  = 8'h02;
    localparam logic [BYTE_W-1:0]    RESET_REPLY_FUNCTION = 8'h03;

    localparam logic MODE_RX_BYTE    = 1'b0;
    localparam logic MODE_TABLE_LOAD = 1'b1;
    localparam logic KIND_RESPONSE   = 1'b0;
    localparam logic KIND_WRITE      = 1'b1;

    localparam logic [2:0] POS_FUNCTION = 3'd1;
    localparam logic [2:0] POS_COUNT    = 3'd5;
    localparam logic [2:0] POS_CRC_LO   = 3'd6;
    localparam logic [2:0] POS_CRC_HI   = 3'd7;

    typedef struct packed {
        logic init;
        logic start;
    } crc_ctl_t;
endpackage
`default_nettype wire

### design/mrr_crc_serial.sv
// Bit-serial CRC-16 unit: folds one byte into the running CRC, one bit per cycle.
`default_nettype none
module mrr_crc_serial
    import mrr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire crc_ctl_t          ctl,
    input  wire logic [BYTE_W-1:0] din,
    output logic      [CRC_W-1:0]  crc,
    output logic                   busy
);
    logic [CRC_W-1:0]  crc_reg;
    logic [BYTE_W-1:0] shift_reg;
    logic [2:0]        cnt_reg;
    logic              busy_reg;
    logic              fb;

    assign fb   = crc_reg[0] ^ shift_reg[0];
    assign crc  = crc_reg;
    assign busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            shift_reg <= '0;
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (ctl.init)
        begin
            crc_reg  <= CRC_INIT;
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctl.start)
        begin
            shift_reg <= din;
            busy_reg  <= 1'b1;
            cnt_reg   <= '0;
        end
        else if (busy_reg)
        begin
            crc_reg   <= {1'b0, crc_reg[CRC_W-1:1]} ^ (fb ? CRC_POLY : '0);
            shift_reg <= {1'b0, shift_reg[BYTE_W-1:1]};
            cnt_reg   <= cnt_reg + 3'd1;
            if (cnt_reg == 3'd7)
            begin
                busy_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

### design/mrr_data_table.sv
// Register data table: one write port, one read port, cleared at reset.
`default_nettype none
module mrr_data_table
    import mrr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   wr_en,
    input  wire logic [TABLE_IDX_W-1:0] wr_idx,
    input  wire logic [BYTE_W-1:0]      wr_data,
    input  wire logic [TABLE_IDX_W-1:0] rd_idx,
    output logic      [BYTE_W-1:0]      rd_data
);
    logic [BYTE_W-1:0] entry_reg [TABLE_DEPTH];

    assign rd_data = entry_reg[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            entry_reg[wr_idx] <= wr_data;
        end
    end
endmodule
`default_nettype wire

### design/modbus_rtu_request_responder_core.sv
// Top level: Modbus RTU request receiver, CRC check and response generator.
// Each request byte is folded into a bit-serial CRC-16, so the input is busy
// until the CRC unit has shifted in the whole byte; table loads and the two
// check bytes do not start the CRC unit. A read response goes out when the
// sink is ready and the same CRC unit has serialized the byte before it; the
// two CRC bytes are read from the CRC register and a write result is a single
// byte marked last. No input is taken while a response is built.
`default_nettype none
`include "assert_macros.svh"
module modbus_rtu_request_responder_core
    import mrr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // [7:0] rx_byte, [10:8] entry_index, [18:11] entry_value, [23:19] zero
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // [0] mode
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // [7:0] out_byte
    output logic      [BYTE_W-1:0]    m_tdata,
    // [0] kind
    output logic                      m_tuser,
    output logic                      m_tlast,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [BYTE_W-1:0]    cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_WRITE,
        S_TX_ADDR,
        S_TX_FUNC,
        S_TX_COUNT,
        S_TX_ZERO,
        S_TX_DATA,
        S_TX_CRC_LO,
        S_TX_CRC_HI
    } state_t;

    state_t                 state_reg, state_next;
    logic [2:0]             rx_pos_reg, rx_pos_next;
    logic [BYTE_W-1:0]      func_reg, func_next;
    logic [BYTE_W-1:0]      count_reg, count_next;
    logic                   matched_reg, matched_next;
    logic [REG_CNT_W-1:0]   reg_idx_reg, reg_idx_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [BYTE_W-1:0]      m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;
    logic                   m_tlast_reg, m_tlast_next;
    logic [BYTE_W-1:0]      reply_addr_reg, reply_func_reg;

    logic [BYTE_W-1:0]      rx_byte, entry_value, table_rd;
    logic [TABLE_IDX_W-1:0] entry_index;
    logic                   in_acc, out_free, tx_go, table_we;
    logic [REG_CNT_W-1:0]   reg_cnt, reg_idx_inc;
    crc_ctl_t               crc_ctl;
    logic [BYTE_W-1:0]      crc_din;
    logic [CRC_W-1:0]       crc;
    logic                   crc_busy;

    assign rx_byte     = s_tdata[7:0];
    assign entry_index = s_tdata[10:8];
    assign entry_value = s_tdata[18:11];

    assign s_tready  = (state_reg == S_IDLE) && !crc_busy;
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign tx_go     = out_free && !crc_busy;
    assign table_we  = in_acc && (s_tuser == MODE_TABLE_LOAD);
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign reg_cnt     = (count_reg > BYTE_W'(REG_LIMIT)) ? REG_CNT_W'(REG_LIMIT)
                                                          : REG_CNT_W'(count_reg);
    assign reg_idx_inc = reg_idx_reg + REG_CNT_W'(1);

    mrr_crc_serial u_crc (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (crc_ctl),
        .din  (crc_din),
        .crc  (crc),
        .busy (crc_busy)
    );

    mrr_data_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (table_we),
        .wr_idx (entry_index),
        .wr_data(entry_value),
        .rd_idx (reg_idx_reg[TABLE_IDX_W-1:0]),
        .rd_data(table_rd)
    );

    always_comb
    begin
        state_next    = state_reg;
        rx_pos_next   = rx_pos_reg;
        func_next     = func_reg;
        count_next    = count_reg;
        matched_next  = matched_reg;
        reg_idx_next  = reg_idx_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        crc_ctl       = '0;
        crc_din       = rx_byte;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (s_tuser == MODE_RX_BYTE))
                begin
                    if (rx_pos_reg <= POS_COUNT)
                    begin
                        crc_ctl.start = 1'b1;
                        if (rx_pos_reg == POS_FUNCTION)
                        begin
                            func_next = rx_byte;
                        end
                        if (rx_pos_reg == POS_COUNT)
                        begin
                            count_next = rx_byte;
                        end
                        rx_pos_next = rx_pos_reg + 3'd1;
                    end
                    else if (rx_pos_reg == POS_CRC_LO)
                    begin
                        matched_next = (rx_byte == crc[7:0]);
                        rx_pos_next  = POS_CRC_HI;
                    end
                    else
                    begin
                        rx_pos_next  = '0;
                        matched_next = 1'b0;
                        crc_ctl.init = 1'b1;
                        reg_idx_next = '0;
                        if (matched_reg && (rx_byte == crc[15:8]))
                        begin
                            state_next = (func_reg > WRITE_FUNC_LIMIT) ? S_WRITE : S_TX_ADDR;
                        end
                    end
                end
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = count_reg;
                    m_tuser_next  = KIND_WRITE;
                    m_tlast_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_TX_ADDR, S_TX_FUNC, S_TX_COUNT, S_TX_ZERO, S_TX_DATA:
            begin
                case (state_reg)
                    S_TX_ADDR:  crc_din = reply_addr_reg;
                    S_TX_FUNC:  crc_din = reply_func_reg;
                    S_TX_COUNT: crc_din = BYTE_W'({reg_cnt, 1'b0});
                    S_TX_ZERO:  crc_din = '0;
                    default:    crc_din = table_rd;
                endcase
                if (tx_go)
                begin
                    crc_ctl.start = 1'b1;
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = crc_din;
                    m_tuser_next  = KIND_RESPONSE;
                    m_tlast_next  = 1'b0;
                    case (state_reg)
                        S_TX_ADDR:  state_next = S_TX_FUNC;
                        S_TX_FUNC:  state_next = S_TX_COUNT;
                        S_TX_COUNT: state_next = (reg_cnt == '0) ? S_TX_CRC_LO : S_TX_ZERO;
                        S_TX_ZERO:  state_next = S_TX_DATA;
                        default:
                        begin
                            reg_idx_next = reg_idx_inc;
                            state_next   = (reg_idx_inc == reg_cnt) ? S_TX_CRC_LO : S_TX_ZERO;
                        end
                    endcase
                end
            end
            S_TX_CRC_LO:
            begin
                if (tx_go)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = crc[7:0];
                    m_tuser_next  = KIND_RESPONSE;
                    m_tlast_next  = 1'b0;
                    state_next    = S_TX_CRC_HI;
                end
            end
            S_TX_CRC_HI:
            begin
                if (tx_go)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = crc[15:8];
                    m_tuser_next  = KIND_RESPONSE;
                    m_tlast_next  = 1'b1;
                    crc_ctl.init  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rx_pos_reg   <= '0;
            func_reg     <= '0;
            count_reg    <= '0;
            matched_reg  <= 1'b0;
            reg_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= KIND_RESPONSE;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rx_pos_reg   <= rx_pos_next;
            func_reg     <= func_next;
            count_reg    <= count_next;
            matched_reg  <= matched_next;
            reg_idx_reg  <= reg_idx_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_addr_reg <= RESET_REPLY_ADDRESS;
            reply_func_reg <= RESET_REPLY_FUNCTION;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_REPLY_ADDRESS:  reply_addr_reg <= cfg_data;
                CFG_REPLY_FUNCTION: reply_func_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    `ASSERT_IMPLY(a_crc_start_idle, clk, rst_n, crc_ctl.start, !crc_busy)
    `ASSERT_IMPLY(a_out_no_overwrite, clk, rst_n,
        (m_tvalid_next && (m_tdata_next != m_tdata_reg || m_tlast_next != m_tlast_reg)),
        (!m_tvalid_reg || m_tready))
    `ASSERT_IMPLY(a_reg_idx_range, clk, rst_n,
        (state_reg == S_TX_ZERO || state_reg == S_TX_DATA), (reg_idx_reg < reg_cnt))
    `ASSERT_NEXT(a_resp_ends_last, clk, rst_n, (state_reg == S_TX_CRC_HI && tx_go),
        (state_reg == S_IDLE && m_tvalid_reg && m_tlast_reg))
endmodule
`default_nettype wire
